// ----- sv/ebrf_pkg.sv -----
// Shared types and constants for the escaped byte receive FIFO.
`timescale 1ns / 1ps
`default_nettype none
package ebrf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned FillW   = 9;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned OutW    = 32;

  localparam logic [CmdW-1:0] CmdRx   = 2'd0;
  localparam logic [CmdW-1:0] CmdRead = 2'd1;
  localparam logic [CmdW-1:0] CmdTake = 2'd2;
  localparam logic [CmdW-1:0] CmdTx   = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgModeIdx   = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgEscIdx    = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgMaskIdx   = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgEndIdx    = 8'd3;

  localparam logic              ModeRequest  = 1'b0;
  localparam logic              ModeUpdate   = 1'b1;
  localparam logic [ByteW-1:0]  EscResetVal  = 8'd125;
  localparam logic [ByteW-1:0]  MaskResetVal = 8'd32;
  localparam logic [ByteW-1:0]  EndResetVal  = 8'd126;
  localparam logic [ByteW-1:0]  ReqMax       = 8'd255;

  typedef struct packed {
    logic exec;
    logic pop;
    logic load_ram;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
  } dp_status_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
    logic [ByteW-1:0] pending;
    logic             ovf;
    logic             parity;
    logic             taken;
    logic             rvalid;
    logic [ByteW-1:0] rdata;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/ebrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ebrf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- sv/ebrf_ctrl.sv -----
// Controller state machine: request handshakes and read sequencing.
`timescale 1ns / 1ps
`default_nettype none
module ebrf_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  input  wire logic [ebrf_pkg::CmdW-1:0]  command_i,
  input  wire logic                       m_axis_tready,
  input  wire ebrf_pkg::dp_status_t       status_i,
  output logic                            s_axis_tready,
  output logic                            m_axis_tvalid,
  output ebrf_pkg::ctrl_cmd_t             cmd_o
);
  import ebrf_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StRead = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    s_axis_tready  = (state_q == StIdle) && (!out_valid_q || m_axis_tready);
    cmd_o.exec     = s_axis_tvalid && s_axis_tready;
    cmd_o.pop      = cmd_o.exec && (command_i == CmdRead) && !status_i.empty;
    cmd_o.load_ram = 1'b0;
    state_d        = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_o.pop) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.load_ram = 1'b1;
        state_d        = StIdle;
      end
      default: state_d = StIdle;
    endcase
    out_valid_d = out_valid_q && !m_axis_tready;
    if ((cmd_o.exec && !cmd_o.pop) || cmd_o.load_ram) begin
      out_valid_d = 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> !out_valid_q)
    else $error("read result would overwrite a pending result");
  a_pop_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |=> (state_q == StRead) && !s_axis_tready)
    else $error("pop did not enter the read wait");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_ram |=> m_axis_tvalid)
    else $error("read result not presented");
`endif

endmodule
`default_nettype wire

// ----- sv/ebrf_dp.sv -----
// Datapath: configuration, unescaping, FIFO pointers, counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module ebrf_dp #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ebrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ebrf_pkg::ByteW-1:0]    cfg_data_i,
  input  wire logic [ebrf_pkg::CmdW-1:0]     command_i,
  input  wire logic [ebrf_pkg::ByteW-1:0]    data_byte_i,
  input  wire ebrf_pkg::ctrl_cmd_t           cmd_i,
  output ebrf_pkg::dp_status_t               status_o,
  output ebrf_pkg::result_t                  result_o
);
  import ebrf_pkg::*;

  localparam int unsigned PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

  logic             mode_q;
  logic [ByteW-1:0] esc_q, mask_q, end_q;

  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             esc_pend_q, esc_pend_d;
  logic [ByteW-1:0] req_q, req_d;

  logic             push_req, push_ok, ovf, taken, parity, full;
  logic [ByteW-1:0] push_byte, ram_rdata;
  result_t          res_q;

  assign full  = (count_q == CntFull);
  assign status_o.empty = (count_q == '0);

  always_comb begin
    wptr_d     = wptr_q;
    rptr_d     = rptr_q;
    count_d    = count_q;
    esc_pend_d = esc_pend_q;
    req_d      = req_q;
    push_req   = 1'b0;
    push_byte  = data_byte_i;
    taken      = 1'b0;
    parity     = 1'b0;
    if (cmd_i.exec) begin
      case (command_i)
        CmdRx: begin
          if (mode_q == ModeUpdate) begin
            push_req = 1'b1;
          end else if (esc_pend_q) begin
            esc_pend_d = 1'b0;
            push_req   = 1'b1;
            push_byte  = data_byte_i ^ mask_q;
          end else if (data_byte_i == esc_q) begin
            esc_pend_d = 1'b1;
          end else if (data_byte_i == end_q) begin
            if (req_q != ReqMax) begin
              req_d = req_q + 8'd1;
            end
          end else begin
            push_req = 1'b1;
          end
        end
        CmdRead: begin
          if (cmd_i.pop) begin
            rptr_d  = (rptr_q == PtrLast) ? '0 : rptr_q + PtrW'(1);
            count_d = count_q - CntW'(1);
          end
        end
        CmdTake: begin
          if (req_q != '0) begin
            req_d = req_q - 8'd1;
            taken = 1'b1;
          end
        end
        CmdTx: parity = (mode_q == ModeUpdate) && (^data_byte_i);
        default: ;
      endcase
    end
    push_ok = push_req && !full;
    ovf     = push_req && full;
    if (push_ok) begin
      wptr_d  = (wptr_q == PtrLast) ? '0 : wptr_q + PtrW'(1);
      count_d = count_q + CntW'(1);
    end
  end

  ebrf_ram #(
    .Width (ByteW),
    .Depth (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (wptr_q),
    .wdata_i (push_byte),
    .re_i    (cmd_i.pop),
    .raddr_i (rptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeRequest;
      esc_q      <= EscResetVal;
      mask_q     <= MaskResetVal;
      end_q      <= EndResetVal;
      wptr_q     <= '0;
      rptr_q     <= '0;
      count_q    <= '0;
      esc_pend_q <= 1'b0;
      req_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgModeIdx: mode_q <= cfg_data_i[0];
          CfgEscIdx:  esc_q  <= cfg_data_i;
          CfgMaskIdx: mask_q <= cfg_data_i;
          CfgEndIdx:  end_q  <= cfg_data_i;
          default: ;
        endcase
      end
      wptr_q     <= wptr_d;
      rptr_q     <= rptr_d;
      count_q    <= count_d;
      esc_pend_q <= esc_pend_d;
      req_q      <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ram) begin
      res_q.rdata   <= ram_rdata;
      res_q.rvalid  <= 1'b1;
      res_q.taken   <= 1'b0;
      res_q.parity  <= 1'b0;
      res_q.ovf     <= 1'b0;
      res_q.pending <= req_q;
      res_q.fill    <= FillW'(count_q);
    end else if (cmd_i.exec && !cmd_i.pop) begin
      res_q.rdata   <= '0;
      res_q.rvalid  <= 1'b0;
      res_q.taken   <= taken;
      res_q.parity  <= parity;
      res_q.ovf     <= ovf;
      res_q.pending <= req_d;
      res_q.fill    <= FillW'(count_d);
    end
  end

  assign result_o = res_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("fill count beyond depth");
  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_ok |=> count_q == $past(count_q) + CntW'(1))
    else $error("accepted byte not counted");
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf |-> full && !push_ok)
    else $error("byte dropped while space was free");
`endif

endmodule
`default_nettype wire

// ----- sv/escaped_byte_rx_fifo_unit.sv -----
// Top level of the escaped byte receive FIFO.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser command, tdata data_byte
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata result fields
//  cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Receive, take and transmit requests register their result directly; a read of a non-empty
// FIFO goes through the registered read port of the byte store, then the result register.
// One request is in work at a time; a new request enters no earlier than the
// cycle in which the previous result is taken on m_axis_tready.
// Reset sets pointers, counters and configuration to their reset values at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module escaped_byte_rx_fifo_unit #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [7:0] data_byte
  input  wire logic [ebrf_pkg::ByteW-1:0]    s_axis_tdata,
  // [1:0] command
  input  wire logic [ebrf_pkg::CmdW-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] read_data, [8] read_valid, [9] request_taken, [10] parity_bit,
  // [11] overflow, [19:12] pending_requests, [28:20] fill_level, [31:29] zero
  output logic [ebrf_pkg::OutW-1:0]          m_axis_tdata,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ebrf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ebrf_pkg::ByteW-1:0]    cfg_data_i
);
  import ebrf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    result;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {(OutW - $bits(result_t))'(0), result};

  ebrf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .command_i     (s_axis_tuser),
    .m_axis_tready (m_axis_tready),
    .status_i      (status),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .cmd_o         (cmd)
  );

  ebrf_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .command_i   (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result)
  );

endmodule
`default_nettype wire
